FILE: rtl/core/u8d_pkg.sv
// Package for the UTF-8 code point decoder.
// Holds the command type passed from the decode front to the result back end,
// byte class constants and default sizes. No dependencies.
package u8d_pkg;

   localparam int CMD_QUEUE_DEPTH = 4;

   localparam int CP_W = 21;

   localparam logic [CP_W-1:0] QMARK_CP = CP_W'(8'h3F);

   localparam logic [7:0] MASK_E0   = 8'hE0;
   localparam logic [7:0] MASK_F0   = 8'hF0;
   localparam logic [7:0] MASK_F8   = 8'hF8;
   localparam logic [7:0] MASK_C0   = 8'hC0;
   localparam logic [7:0] LEAD2_PAT = 8'hC0;
   localparam logic [7:0] LEAD3_PAT = 8'hE0;
   localparam logic [7:0] LEAD4_PAT = 8'hF0;
   localparam logic [7:0] CONT_PAT  = 8'h80;
   localparam logic [7:0] PAY2_MASK = 8'h1F;
   localparam logic [7:0] PAY3_MASK = 8'h0F;
   localparam logic [7:0] PAY4_MASK = 8'h07;
   localparam logic [7:0] CONT_MASK = 8'h3F;

   localparam logic [2:0] SEQ_NONE = 3'd0;
   localparam logic [2:0] SEQ_LEN2 = 3'd2;
   localparam logic [2:0] SEQ_LEN3 = 3'd3;
   localparam logic [2:0] SEQ_LEN4 = 3'd4;

   // One decoded byte: rep_count replaced '?' items, then an optional tail item.
   typedef struct packed {
      logic [1:0]      rep_count;
      logic            has_tail;
      logic [CP_W-1:0] tail_cp;
      logic            tail_replaced;
      logic            tail_end;
   } cmd_type;

endpackage

FILE: rtl/core/utf8_codepoint_decoder.sv
// Top level of the UTF-8 code point decoder: decode front, command queue,
// result back end. Depends on u8d_pkg, u8d_front, u8d_cmd_queue, u8d_back.
//
//   channel  | handshake    | payload
//   ---------+--------------+-----------------------------------------------
//   request  | push / full  | req_text_byte
//   response | pop / empty  | rsp_code_point, rsp_replaced, rsp_text_end,
//            |              | rsp_last_in_run
//
// One byte is taken per cycle while the queue is not full; each byte gives 0
// to 4 items, one item per cycle from the result register unless it waits on pop.
// A broken sequence yields up to four items from one command; bytes that keep
// coming meanwhile queue up, so full can rise even with pop held
// high, and stays up while the command queue (QueueDepth entries) waits on pop.
// Synchronous reset closes any open sequence and empties queue and result register.
module utf8_codepoint_decoder #(
   parameter int QueueDepth = u8d_pkg::CMD_QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   output logic                     full,
   input  logic [7:0]               req_text_byte,
   output logic                     empty,
   input  logic                     pop,
   output logic [u8d_pkg::CP_W-1:0] rsp_code_point,
   output logic                     rsp_replaced,
   output logic                     rsp_text_end,
   output logic                     rsp_last_in_run
);
   import u8d_pkg::*;

   cmd_type wr_cmd, head;
   logic    cmd_valid, q_full, q_valid, rd_en;

   assign full = q_full;

   u8d_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .req_text_byte (req_text_byte),
      .q_full        (q_full),
      .cmd_valid     (cmd_valid),
      .cmd           (wr_cmd)
   );

   u8d_cmd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_valid),
      .wr_cmd  (wr_cmd),
      .rd_en   (rd_en),
      .rd_cmd  (head),
      .q_full  (q_full),
      .q_valid (q_valid)
   );

   u8d_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .head            (head),
      .rd_en           (rd_en),
      .pop             (pop),
      .empty           (empty),
      .rsp_code_point  (rsp_code_point),
      .rsp_replaced    (rsp_replaced),
      .rsp_text_end    (rsp_text_end),
      .rsp_last_in_run (rsp_last_in_run)
   );

endmodule

FILE: rtl/core/u8d_front.sv
// Decode front end: accepts text bytes, tracks the open UTF-8 sequence and
// turns each byte into at most one back end command. Depends on u8d_pkg.
module u8d_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [7:0]       req_text_byte,
   input  logic             q_full,
   output logic             cmd_valid,
   output u8d_pkg::cmd_type cmd
);
   import u8d_pkg::*;

   logic [2:0]      seq_len_ff, seq_len_in;
   logic [1:0]      held_ff, held_in;
   logic [CP_W-1:0] partial_ff, partial_in;

   logic            accept;
   logic            is_cont;
   logic [1:0]      held_inc;
   logic [CP_W-1:0] shifted;
   logic [7:0]      b;

   assign b        = req_text_byte;
   assign is_cont  = (b & MASK_C0) == CONT_PAT;
   assign held_inc = held_ff + 2'd1;
   assign shifted  = {partial_ff[CP_W-7:0], b[5:0]};
   assign accept   = push && !q_full;

   always_comb begin
      cmd        = '0;
      seq_len_in = seq_len_ff;
      held_in    = held_ff;
      partial_in = partial_ff;
      if (seq_len_ff != SEQ_NONE && is_cont) begin
         if ({1'b0, held_inc} + 3'd1 >= seq_len_ff) begin
            cmd.has_tail = 1'b1;
            cmd.tail_cp  = shifted;
            seq_len_in   = SEQ_NONE;
            held_in      = '0;
            partial_in   = '0;
         end else begin
            held_in    = held_inc;
            partial_in = shifted;
         end
      end else begin
         // broken sequence: lead plus held continuations become '?'
         if (seq_len_ff != SEQ_NONE) begin
            cmd.rep_count = held_inc;
         end
         seq_len_in = SEQ_NONE;
         held_in    = '0;
         partial_in = '0;
         priority if (b == 8'h00) begin
            cmd.has_tail = 1'b1;
            cmd.tail_end = 1'b1;
         end else if (!b[7]) begin
            cmd.has_tail = 1'b1;
            cmd.tail_cp  = CP_W'(b);
         end else if ((b & MASK_E0) == LEAD2_PAT) begin
            seq_len_in = SEQ_LEN2;
            partial_in = CP_W'(b & PAY2_MASK);
         end else if ((b & MASK_F0) == LEAD3_PAT) begin
            seq_len_in = SEQ_LEN3;
            partial_in = CP_W'(b & PAY3_MASK);
         end else if ((b & MASK_F8) == LEAD4_PAT) begin
            seq_len_in = SEQ_LEN4;
            partial_in = CP_W'(b & PAY4_MASK);
         end else begin
            cmd.has_tail      = 1'b1;
            cmd.tail_cp       = QMARK_CP;
            cmd.tail_replaced = 1'b1;
         end
      end
   end

   assign cmd_valid = accept && (cmd.has_tail || cmd.rep_count != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_len_ff <= SEQ_NONE;
         held_ff    <= '0;
         partial_ff <= '0;
      end else if (accept) begin
         seq_len_ff <= seq_len_in;
         held_ff    <= held_in;
         partial_ff <= partial_in;
      end
   end

endmodule

FILE: rtl/core/u8d_cmd_queue.sv
// Command queue between the decode front and the result back end.
// Register file with read and write pointers. Depends on u8d_pkg.
module u8d_cmd_queue #(
   parameter int Depth = u8d_pkg::CMD_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  u8d_pkg::cmd_type wr_cmd,
   input  logic             rd_en,
   output u8d_pkg::cmd_type rd_cmd,
   output logic             q_full,
   output logic             q_valid
);
   import u8d_pkg::*;

   localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CW = $clog2(Depth + 1);

   cmd_type         mem_ff [Depth];
   logic [PW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]   count_ff;

   assign q_full  = count_ff == CW'(Depth);
   assign q_valid = count_ff != '0;
   assign rd_cmd  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (rd_en) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (wr_en && !rd_en) begin
            count_ff <= count_ff + 1'b1;
         end else if (rd_en && !wr_en) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: rtl/core/u8d_back.sv
// Result back end: expands each queued command into result items, one per
// cycle unless held by pop, into the result register. Depends on u8d_pkg.
module u8d_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  u8d_pkg::cmd_type         head,
   output logic                     rd_en,
   input  logic                     pop,
   output logic                     empty,
   output logic [u8d_pkg::CP_W-1:0] rsp_code_point,
   output logic                     rsp_replaced,
   output logic                     rsp_text_end,
   output logic                     rsp_last_in_run
);
   import u8d_pkg::*;

   logic [1:0]      idx_ff;
   logic            out_valid_ff;
   logic [CP_W-1:0] cp_ff;
   logic            rep_ff, end_ff, last_ff;

   logic            advance, in_rep, last_now;

   assign advance  = q_valid && (!out_valid_ff || pop);
   assign in_rep   = idx_ff < head.rep_count;
   assign last_now = in_rep ? (idx_ff == head.rep_count - 2'd1) && !head.has_tail : 1'b1;
   assign rd_en    = advance && last_now;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         if (advance) begin
            out_valid_ff <= 1'b1;
            idx_ff       <= last_now ? 2'd0 : idx_ff + 2'd1;
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cp_ff   <= in_rep ? QMARK_CP : head.tail_cp;
         rep_ff  <= in_rep ? 1'b1 : head.tail_replaced;
         end_ff  <= in_rep ? 1'b0 : head.tail_end;
         last_ff <= last_now;
      end
   end

   assign empty           = !out_valid_ff;
   assign rsp_code_point  = cp_ff;
   assign rsp_replaced    = rep_ff;
   assign rsp_text_end    = end_ff;
   assign rsp_last_in_run = last_ff;

endmodule

FILE: bench/utf8_codepoint_decoder_tb.sv
// Testbench for utf8_codepoint_decoder: a directed byte run and then random UTF-8 text.
// The scoreboard class predicts the code point items and checks them in order.
// Depends on u8d_pkg and the decoder RTL.
module utf8_codepoint_decoder_tb;
   import u8d_pkg::*;

   localparam int ITEM_COUNT   = 470;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 16;

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            replaced;
      logic            text_end;
      logic            last_in_run;
   } cp_item_type;

   class cp_scoreboard;
      cp_item_type     expected_q[$];
      logic [2:0]      open_len;
      int              cont_seen;
      logic [CP_W-1:0] code_acc;
      int              errors;

      function new();
         close_seq();
         errors = 0;
      endfunction

      function void close_seq();
         open_len  = SEQ_NONE;
         cont_seen = 0;
         code_acc  = '0;
      endfunction

      function void add_item(logic [CP_W-1:0] cp, logic rep, logic is_end);
         cp_item_type it;
         it.code_point  = cp;
         it.replaced    = rep;
         it.text_end    = is_end;
         it.last_in_run = 1'b0;
         expected_q.push_back(it);
      endfunction

      function void decode_fresh(logic [7:0] text_b);
         if (text_b == 8'h00) begin
            close_seq();
            add_item('0, 1'b0, 1'b1);
         end else if (text_b < CONT_PAT) begin
            add_item(CP_W'(text_b), 1'b0, 1'b0);
         end else if ((text_b & MASK_E0) == LEAD2_PAT) begin
            open_len  = SEQ_LEN2;
            cont_seen = 0;
            code_acc  = CP_W'(text_b & PAY2_MASK);
         end else if ((text_b & MASK_F0) == LEAD3_PAT) begin
            open_len  = SEQ_LEN3;
            cont_seen = 0;
            code_acc  = CP_W'(text_b & PAY3_MASK);
         end else if ((text_b & MASK_F8) == LEAD4_PAT) begin
            open_len  = SEQ_LEN4;
            cont_seen = 0;
            code_acc  = CP_W'(text_b & PAY4_MASK);
         end else begin
            add_item(QMARK_CP, 1'b1, 1'b0);
         end
      endfunction

      function void note_byte(logic [7:0] text_b);
         int          first_idx;
         cp_item_type tail;
         first_idx = expected_q.size();
         if (open_len != SEQ_NONE) begin
            if ((text_b & MASK_C0) == CONT_PAT) begin
               code_acc = {code_acc[CP_W-7:0], text_b[5:0]};
               cont_seen++;
               if (cont_seen + 1 >= int'(open_len)) begin
                  add_item(code_acc, 1'b0, 1'b0);
                  close_seq();
               end
            end else begin
               // broken sequence: one '?' for the lead, one per held continuation
               add_item(QMARK_CP, 1'b1, 1'b0);
               for (int i = 0; i < cont_seen; i++) add_item(QMARK_CP, 1'b1, 1'b0);
               close_seq();
               decode_fresh(text_b);
            end
         end else begin
            decode_fresh(text_b);
         end
         if (expected_q.size() > first_idx) begin
            tail = expected_q.pop_back();
            tail.last_in_run = 1'b1;
            expected_q.push_back(tail);
         end
      endfunction

      function void check_item(cp_item_type got);
         cp_item_type want;
         if (expected_q.size() == 0) begin
            $error("unexpected item: code_point %0h", got.code_point);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.code_point !== want.code_point) begin
            $error("code_point: expected %0h, actual %0h", want.code_point, got.code_point);
            errors++;
         end
         if (got.replaced !== want.replaced) begin
            $error("replaced: expected %0b, actual %0b", want.replaced, got.replaced);
            errors++;
         end
         if (got.text_end !== want.text_end) begin
            $error("text_end: expected %0b, actual %0b", want.text_end, got.text_end);
            errors++;
         end
         if (got.last_in_run !== want.last_in_run) begin
            $error("last_in_run: expected %0b, actual %0b", want.last_in_run,
                   got.last_in_run);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic            clock;
   logic            reset         = 1'b1;
   logic            push          = 1'b0;
   logic [7:0]      req_text_byte = 8'h00;
   logic            pop           = 1'b0;
   logic            full;
   logic            empty;
   logic [CP_W-1:0] rsp_code_point;
   logic            rsp_replaced;
   logic            rsp_text_end;
   logic            rsp_last_in_run;

   cp_scoreboard sb = new();

   int          sent       = 0;
   int          burst_left = 0;
   int          idle_cycles = 0;
   logic [15:0] stall_cyc  = '0;

   logic [7:0] directed_bytes [27] = '{
      8'h00, 8'h41, 8'h3F, 8'h7F,
      8'hC3, 8'hA9,
      8'hE2, 8'h82, 8'hAC,
      8'hF7, 8'hBF, 8'hBF, 8'hBF,
      8'h80, 8'hF8, 8'hFF,
      8'hF0, 8'h80, 8'h80, 8'h00,
      8'hE2, 8'h82, 8'h41,
      8'hC0, 8'hE0, 8'h80, 8'h80
   };

   utf8_codepoint_decoder u_dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_text_byte   (req_text_byte),
      .empty           (empty),
      .pop             (pop),
      .rsp_code_point  (rsp_code_point),
      .rsp_replaced    (rsp_replaced),
      .rsp_text_end    (rsp_text_end),
      .rsp_last_in_run (rsp_last_in_run)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) sb.note_byte(req_text_byte);
         if (pop && !empty)
            sb.check_item({rsp_code_point, rsp_replaced, rsp_text_end, rsp_last_in_run});
      end
   end

   // receiver stall pattern: free run, random, periodic, long stalls
   always @(negedge clock) begin
      stall_cyc <= stall_cyc + 1'b1;
      case (stall_cyc[8:7])
         2'd0: pop <= 1'b1;
         2'd1: pop <= 1'($urandom_range(0, 1));
         2'd2: pop <= (stall_cyc[1:0] == 2'd0);
         default: pop <= (stall_cyc[4:3] == 2'd0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_byte(logic [7:0] text_b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            @(negedge clock);
            push <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      push          <= 1'b1;
      req_text_byte <= text_b;
      do @(posedge clock); while (full);
      sent++;
   endtask

   task automatic send_seq(int len, int conts);
      case (len)
         2: send_byte(LEAD2_PAT | (8'($urandom) & PAY2_MASK));
         3: send_byte(LEAD3_PAT | (8'($urandom) & PAY3_MASK));
         default: send_byte(LEAD4_PAT | (8'($urandom) & PAY4_MASK));
      endcase
      repeat (conts) send_byte(CONT_PAT | (8'($urandom) & CONT_MASK));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      push <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      int         kind;
      int         len;
      bit         paused;
      logic [7:0] breaker;
      paused = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
      wait_drained();

      while (sent < ITEM_COUNT) begin
         kind = $urandom_range(0, 99);
         len  = $urandom_range(2, 4);
         if (kind < 25) begin
            send_byte(8'($urandom_range(1, 127)));
         end else if (kind < 65) begin
            send_seq(len, len - 1);
         end else if (kind < 78) begin
            send_seq(len, $urandom_range(0, len - 2));
            if ($urandom_range(0, 3) == 0) begin
               breaker = 8'h00;
            end else begin
               do breaker = 8'($urandom); while ((breaker & MASK_C0) == CONT_PAT);
            end
            send_byte(breaker);
         end else if (kind < 86) begin
            send_byte(8'($urandom));
         end else if (kind < 90) begin
            send_byte(8'h00);
         end else if (kind < 94) begin
            send_byte(8'($urandom_range(8'hF8, 8'hFF)));
         end else begin
            send_byte(8'($urandom_range(8'h80, 8'hBF)));
         end
         if (!paused && sent >= ITEM_COUNT / 2) begin
            paused = 1'b1;
            wait_drained();
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
